// ----- rtl/clcd_pkg.sv -----
// Shared types, codes and constants of the character LCD nibble writer.
package clcd_pkg;

    localparam int unsigned WAIT_W = 16;
    localparam int unsigned NIB_W  = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned COL_W  = 6;
    localparam int unsigned PH_W   = 3;
    localparam int unsigned BIDX_W = 2;
    localparam int unsigned CIDX_W = 2;

    localparam logic [WAIT_W-1:0] PULSE_WAIT_RST   = 16'd1000;
    localparam logic [WAIT_W-1:0] COMMAND_WAIT_RST = 16'd10000;
    localparam logic [WAIT_W-1:0] DATA_WAIT_RST    = 16'd1000;

    localparam logic [BYTE_W-1:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_SET_DDRAM = 8'h80;

    // Event phases within one byte
    localparam logic [PH_W-1:0] PH_HI_EN   = 3'd0;
    localparam logic [PH_W-1:0] PH_HI_LOW  = 3'd1;
    localparam logic [PH_W-1:0] PH_LO_EN   = 3'd2;
    localparam logic [PH_W-1:0] PH_LO_LOW  = 3'd3;
    localparam logic [PH_W-1:0] PH_SETTLE  = 3'd4;

    localparam logic [BIDX_W-1:0] INIT_LAST_IDX = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_COMMAND = 3'd0,
        OP_DATA    = 3'd1,
        OP_CURSOR  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_INIT    = 3'd4
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        CFG_PULSE_WAIT   = 2'd0,
        CFG_COMMAND_WAIT = 2'd1,
        CFG_DATA_WAIT    = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SEND = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              emit;
        logic              init;
        logic              last;
        logic [PH_W-1:0]   phase;
        logic [BIDX_W-1:0] byte_idx;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [BYTE_W-1:0] init_byte(input logic [BIDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = CMD_FUNC_SET;
            2'd1:    b = CMD_DISP_ON;
            2'd2:    b = CMD_ENTRY;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/clcd_if.sv -----
// Valid/ready channel interfaces for requests and pin events.
interface clcd_req_if;
    logic                       valid;
    logic                       ready;
    logic [clcd_pkg::OP_W-1:0]   op;
    logic [clcd_pkg::BYTE_W-1:0] value;
    logic                       row;
    logic [clcd_pkg::COL_W-1:0]  col;

    modport source (output valid, op, value, row, col, input ready);
    modport sink   (input valid, op, value, row, col, output ready);
endinterface

interface clcd_evt_if;
    logic                       valid;
    logic                       ready;
    logic [clcd_pkg::NIB_W-1:0]  nibble;
    logic                       reg_select;
    logic                       enable;
    logic [clcd_pkg::WAIT_W-1:0] hold;
    logic                       last;

    modport source (output valid, nibble, reg_select, enable, hold, last, input ready);
    modport sink   (input valid, nibble, reg_select, enable, hold, last, output ready);
endinterface

// ----- rtl/clcd_ctrl.sv -----
// Sequencer that walks the pin events of each request.
module clcd_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic [clcd_pkg::OP_W-1:0] i_req_op,
    input  clcd_pkg::t_status        i_status,
    output logic                     o_req_ready,
    output clcd_pkg::t_cmd           o_cmd
);

    clcd_pkg::t_state r_state, n_state;
    logic [clcd_pkg::PH_W-1:0]   r_phase, n_phase;
    logic [clcd_pkg::BIDX_W-1:0] r_byte_idx, n_byte_idx;
    logic                        r_init, n_init;

    logic accept;
    logic op_known;
    logic ev_last;
    logic byte_end;

    assign op_known = (i_req_op == clcd_pkg::OP_COMMAND) || (i_req_op == clcd_pkg::OP_DATA)
                   || (i_req_op == clcd_pkg::OP_CURSOR)  || (i_req_op == clcd_pkg::OP_CLEAR)
                   || (i_req_op == clcd_pkg::OP_INIT);
    assign accept   = i_req_valid && (r_state == clcd_pkg::S_IDLE);
    assign byte_end = (r_phase == clcd_pkg::PH_SETTLE);
    assign ev_last  = byte_end && (!r_init || (r_byte_idx == clcd_pkg::INIT_LAST_IDX));

    // Next state
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_init     = r_init;
        unique case (r_state)
            clcd_pkg::S_IDLE: begin
                if (accept && op_known) begin
                    n_state    = clcd_pkg::S_SEND;
                    n_phase    = clcd_pkg::PH_HI_EN;
                    n_byte_idx = '0;
                    n_init     = (i_req_op == clcd_pkg::OP_INIT);
                end
            end
            clcd_pkg::S_SEND: begin
                if (i_status.out_free) begin
                    if (byte_end) begin
                        n_phase    = clcd_pkg::PH_HI_EN;
                        n_byte_idx = r_byte_idx + 1'b1;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                    if (ev_last) begin
                        n_state = clcd_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = clcd_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready    = 1'b0;
        o_cmd          = '0;
        o_cmd.phase    = r_phase;
        o_cmd.byte_idx = r_byte_idx;
        o_cmd.init     = r_init;
        o_cmd.last     = ev_last;
        unique case (r_state)
            clcd_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = accept && op_known;
            end
            clcd_pkg::S_SEND: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= clcd_pkg::S_IDLE;
            r_phase    <= '0;
            r_byte_idx <= '0;
            r_init     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_byte_idx <= n_byte_idx;
            r_init     <= n_init;
        end
    end

endmodule

// ----- rtl/clcd_dp.sv -----
// Datapath: wait registers, byte latch and the event output register.
module clcd_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [clcd_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [clcd_pkg::WAIT_W-1:0]  i_cfg_wdata,
    input  logic [clcd_pkg::OP_W-1:0]    i_op,
    input  logic [clcd_pkg::BYTE_W-1:0]  i_value,
    input  logic                         i_row,
    input  logic [clcd_pkg::COL_W-1:0]   i_col,
    input  clcd_pkg::t_cmd               i_cmd,
    input  logic                         i_out_ready,
    output clcd_pkg::t_status            o_status,
    output logic                         o_out_valid,
    output logic [clcd_pkg::NIB_W-1:0]   o_nibble,
    output logic                         o_reg_select,
    output logic                         o_enable,
    output logic [clcd_pkg::WAIT_W-1:0]  o_hold,
    output logic                         o_last
);

    logic [clcd_pkg::WAIT_W-1:0] r_pulse_wait, r_command_wait, r_data_wait;
    logic [clcd_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic                        r_rs;
    logic                        r_out_valid;
    logic [clcd_pkg::NIB_W-1:0]  r_nibble;
    logic                        r_reg_select;
    logic                        r_enable;
    logic [clcd_pkg::WAIT_W-1:0] r_hold;
    logic                        r_last;

    logic [clcd_pkg::BYTE_W-1:0] ev_byte;
    logic [clcd_pkg::NIB_W-1:0]  ev_nibble;
    logic                        ev_enable;
    logic [clcd_pkg::WAIT_W-1:0] ev_hold;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_wait   <= clcd_pkg::PULSE_WAIT_RST;
            r_command_wait <= clcd_pkg::COMMAND_WAIT_RST;
            r_data_wait    <= clcd_pkg::DATA_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clcd_pkg::CFG_PULSE_WAIT:   r_pulse_wait   <= i_cfg_wdata;
                clcd_pkg::CFG_COMMAND_WAIT: r_command_wait <= i_cfg_wdata;
                clcd_pkg::CFG_DATA_WAIT:    r_data_wait    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Byte for single-byte requests
    always_comb begin
        unique case (i_op) inside
            clcd_pkg::OP_COMMAND, clcd_pkg::OP_DATA: n_byte = i_value;
            clcd_pkg::OP_CURSOR: n_byte = clcd_pkg::CMD_SET_DDRAM | {1'b0, i_row, i_col};
            default:             n_byte = clcd_pkg::CMD_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= n_byte;
            r_rs   <= (i_op == clcd_pkg::OP_DATA);
        end
    end

    assign ev_byte   = i_cmd.init ? clcd_pkg::init_byte(i_cmd.byte_idx) : r_byte;
    assign ev_nibble = (i_cmd.phase == clcd_pkg::PH_HI_EN || i_cmd.phase == clcd_pkg::PH_HI_LOW)
                     ? ev_byte[clcd_pkg::BYTE_W-1:clcd_pkg::NIB_W]
                     : ev_byte[clcd_pkg::NIB_W-1:0];
    assign ev_enable = (i_cmd.phase == clcd_pkg::PH_HI_EN) || (i_cmd.phase == clcd_pkg::PH_LO_EN);
    assign ev_hold   = (i_cmd.phase != clcd_pkg::PH_SETTLE) ? r_pulse_wait
                     : (r_rs ? r_data_wait : r_command_wait);

    // Output register: load on emit, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_nibble     <= ev_nibble;
            r_reg_select <= r_rs;
            r_enable     <= ev_enable;
            r_hold       <= ev_hold;
            r_last       <= i_cmd.last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_nibble     = r_nibble;
    assign o_reg_select = r_reg_select;
    assign o_enable     = r_enable;
    assign o_hold       = r_hold;
    assign o_last       = r_last;

endmodule

// ----- rtl/char_lcd_nibble_writer_unit.sv -----
// Top level of the character LCD nibble writer: controller, datapath, checks.
//
//  channel  | dir | word                           | handshake
//  ---------+-----+--------------------------------+-------------------
//  i_req    | in  | op, value, row, col            | valid/ready
//  o_evt    | out | nibble, reg_select, enable,    | valid/ready
//           |     | hold, last                     |
//  cfg      | in  | i_cfg_index, i_cfg_wdata       | i_cfg_we, no wait
//
// A request is taken when the sequencer is idle. Each byte then yields five
// event words, one per cycle while the output register drains; an unknown
// op is taken and dropped. The single output register sets the pace:
// a stalled sink holds the sequencer on the current event. The next request
// is taken while the final event of the previous one still waits in that
// register. Synchronous active-low reset clears the sequencer and output
// valid and loads the wait registers with their default values.
module char_lcd_nibble_writer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    clcd_req_if.sink                     i_req,
    clcd_evt_if.source                   o_evt,
    input  logic                         i_cfg_we,
    input  logic [clcd_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [clcd_pkg::WAIT_W-1:0]  i_cfg_wdata
);

    clcd_pkg::t_cmd    cmd;
    clcd_pkg::t_status status;

    // Sequencer: phase and byte counters, request handshake
    clcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .i_status    (status),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // Datapath: byte build, nibble split, hold select, output word register
    clcd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (i_req.op),
        .i_value      (i_req.value),
        .i_row        (i_req.row),
        .i_col        (i_req.col),
        .i_cmd        (cmd),
        .i_out_ready  (o_evt.ready),
        .o_status     (status),
        .o_out_valid  (o_evt.valid),
        .o_nibble     (o_evt.nibble),
        .o_reg_select (o_evt.reg_select),
        .o_enable     (o_evt.enable),
        .o_hold       (o_evt.hold),
        .o_last       (o_evt.last)
    );

    // No request is taken while events of the previous one are still issued
    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !i_req.ready)
        else $error("request ready while events are being issued");

    // A started request holds the request channel off on the next cycle
    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !i_req.ready)
        else $error("request channel open right after a request started");

    // Issuing the final event frees the sequencer on the next cycle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.last) |=> i_req.ready)
        else $error("sequencer not idle after final event");

    // The settle event always closes a byte with enable low
    a_settle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.phase == clcd_pkg::PH_SETTLE) |=> (o_evt.valid && !o_evt.enable))
        else $error("settle event issued with enable high");

endmodule

// ----- bench/tb_char_lcd_nibble_writer_unit.sv -----
// Self-checking testbench for the character LCD nibble writer: requests in, pin event words out.
module tb_char_lcd_nibble_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import clcd_pkg::*;

    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned MAX_GAP        = 7;     // per-word idle draw, both sides
    localparam int unsigned RX_HOLD_CYCLES = 120;   // long sink hold-off, fills the block
    localparam int unsigned IDLE_SETTLE    = 8;     // covers a dropped op still in flight
    localparam int unsigned TAIL_CYCLES    = 20;    // watch for stray words after the drain
    localparam int unsigned DRAIN_LIMIT    = 50000;
    localparam int unsigned MAX_REPORTS    = 30;

    // Codes outside the documented lists: unused ops and the unmapped register slot.
    localparam logic [OP_W-1:0]   OP_FIRST_UNUSED = 3'd5;
    localparam logic [OP_W-1:0]   OP_LAST_CODE    = 3'd7;
    localparam logic [CIDX_W-1:0] CFG_SPARE       = 2'd3;

    // DDRAM address offset of the second display line.
    localparam logic [6:0] ROW2_BASE = 7'h40;

    // One pin event word as it leaves the block.
    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              reg_select;
        logic              enable;
        logic [WAIT_W-1:0] hold;
        logic              last;
    } t_pin_event;

    // Predicts the pin event stream of each request and checks the words that come out.
    class lcd_pin_scoreboard;
        t_pin_event        pin_q[$];
        logic [WAIT_W-1:0] pulse_wait;
        logic [WAIT_W-1:0] command_wait;
        logic [WAIT_W-1:0] data_wait;
        logic [BYTE_W-1:0] byte_latch;
        logic              select_latch;
        logic [OP_W-1:0]   op_latch;
        logic [4:0]        step_count;
        int unsigned       errors;
        int unsigned       events_checked;
        int unsigned       requests;
        int unsigned       op_seen [8];

        function void clear_state();
            pulse_wait   = PULSE_WAIT_RST;
            command_wait = COMMAND_WAIT_RST;
            data_wait    = DATA_WAIT_RST;
            byte_latch   = '0;
            select_latch = 1'b0;
            op_latch     = '0;
            step_count   = '0;
            pin_q.delete();
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [WAIT_W-1:0] val);
            case (idx)
                CFG_PULSE_WAIT:   pulse_wait   = val;
                CFG_COMMAND_WAIT: command_wait = val;
                CFG_DATA_WAIT:    data_wait    = val;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pin_q.size();
        endfunction

        // Five words per byte: strobe the high nibble, then the low one, then settle.
        function void push_byte(logic [BYTE_W-1:0] b, logic rs, logic fin);
            logic [WAIT_W-1:0] settle;
            settle = rs ? data_wait : command_wait;
            pin_q.push_back('{b[7:4], rs, 1'b1, pulse_wait, 1'b0});
            pin_q.push_back('{b[7:4], rs, 1'b0, pulse_wait, 1'b0});
            pin_q.push_back('{b[3:0], rs, 1'b1, pulse_wait, 1'b0});
            pin_q.push_back('{b[3:0], rs, 1'b0, pulse_wait, 1'b0});
            pin_q.push_back('{b[3:0], rs, 1'b0, settle, fin});
            byte_latch   = b;
            select_latch = rs;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value,
                                   logic row, logic [COL_W-1:0] col);
            logic [6:0] addr;
            int         start_len;
            requests++;
            op_seen[op]++;
            start_len = pin_q.size();
            case (op)
                OP_COMMAND: push_byte(value, 1'b0, 1'b1);
                OP_DATA:    push_byte(value, 1'b1, 1'b1);
                OP_CURSOR: begin
                    addr = row ? ROW2_BASE + col : {1'b0, col};
                    push_byte(CMD_SET_DDRAM | {1'b0, addr}, 1'b0, 1'b1);
                end
                OP_CLEAR:   push_byte(CMD_CLEAR, 1'b0, 1'b1);
                OP_INIT: begin
                    push_byte(CMD_FUNC_SET, 1'b0, 1'b0);
                    push_byte(CMD_DISP_ON, 1'b0, 1'b0);
                    push_byte(CMD_ENTRY, 1'b0, 1'b0);
                    push_byte(CMD_CLEAR, 1'b0, 1'b1);
                end
                default: return;  // unused op: dropped, nothing changes
            endcase
            op_latch   = op;
            step_count = 5'(pin_q.size() - start_len);
        endfunction

        task report_mismatch(input string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task check_event(input t_pin_event got);
            t_pin_event want;
            events_checked++;
            if (pin_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word nib=%h rs=%b en=%b hold=%h last=%b",
                                          got.nibble, got.reg_select, got.enable, got.hold,
                                          got.last));
                return;
            end
            want = pin_q.pop_front();
            if (got.nibble !== want.nibble)
                report_mismatch($sformatf("nibble %h, want %h", got.nibble, want.nibble));
            if (got.reg_select !== want.reg_select)
                report_mismatch($sformatf("reg_select %b, want %b",
                                          got.reg_select, want.reg_select));
            if (got.enable !== want.enable)
                report_mismatch($sformatf("enable %b, want %b", got.enable, want.enable));
            if (got.hold !== want.hold)
                report_mismatch($sformatf("hold %h, want %h", got.hold, want.hold));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [WAIT_W-1:0] i_cfg_wdata;

    clcd_req_if req_ch ();
    clcd_evt_if evt_ch ();

    lcd_pin_scoreboard sb;

    bit idle_on;       // both sides draw random gaps while set
    bit rx_hold_req;   // ask the sink process for one long hold-off

    char_lcd_nibble_writer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_evt       (evt_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    // Offer one request word; return at the edge that accepts it, valid still high so a
    // back-to-back word can follow without a bubble.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] value,
                                input logic row, input logic [COL_W-1:0] col);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        req_ch.row   <= row;
        req_ch.col   <= col;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(op, value, row, col);
    endtask

    // Mostly legal ops with random content; a few unused codes as noise.
    task automatic send_random();
        logic [OP_W-1:0] op;
        if ($urandom_range(0, 99) < 8)
            op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        else
            op = OP_W'($urandom_range(OP_COMMAND, OP_INIT));
        send_request(op, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     COL_W'($urandom_range(0, 63)));
    endtask

    // Drop valid, then hold the sender until every predicted word has come back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Keep the write enable high across a run of writes; the caller drops it.
    task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [WAIT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_waits(input logic [WAIT_W-1:0] pw, input logic [WAIT_W-1:0] cw,
                                 input logic [WAIT_W-1:0] dw, input bit poke_spare);
        put_reg(CFG_PULSE_WAIT, pw);
        put_reg(CFG_COMMAND_WAIT, cw);
        put_reg(CFG_DATA_WAIT, dw);
        // The unmapped slot must leave every wait register alone.
        if (poke_spare)
            put_reg(CFG_SPARE, WAIT_W'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    // One random phase: reprogram while idle, then stream requests. Halfway through the
    // sender pauses until the block has drained; a squeeze phase also holds off the sink
    // long enough that the output register backs up into the request port.
    task automatic run_phase(input logic [WAIT_W-1:0] pw, input logic [WAIT_W-1:0] cw,
                             input logic [WAIT_W-1:0] dw, input int count, input bit idle,
                             input bit squeeze, input bit poke_spare);
        wait_for_drain();
        repeat (IDLE_SETTLE) @(posedge i_clk);
        program_waits(pw, cw, dw, poke_spare);
        idle_on = idle;
        for (int i = 0; i < count; i++) begin
            if (squeeze && i == 4)
                rx_hold_req = 1'b1;
            if (i == count / 2)
                wait_for_drain();
            send_random();
        end
    endtask

    // Sink side: draw a stall per word, take the word, check it against the oldest
    // prediction. A pending hold-off request replaces one draw with a long stall.
    initial begin : sink_proc
        int         stall;
        t_pin_event got;
        evt_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                stall       = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                evt_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            evt_ch.ready <= 1'b1;
            do @(posedge i_clk); while (evt_ch.valid !== 1'b1);
            got = '{evt_ch.nibble, evt_ch.reg_select, evt_ch.enable, evt_ch.hold, evt_ch.last};
            sb.check_event(got);
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int unsigned n;
        sb = new;
        sb.clear_state();
        idle_on     = 1'b1;
        rx_hold_req = 1'b0;

        // Hold every input at a known value through reset.
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_PULSE_WAIT;
        i_cfg_wdata  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_COMMAND;
        req_ch.value <= '0;
        req_ch.row   <= 1'b0;
        req_ch.col   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run on the reset wait values so their defaults get checked too.
        send_request(OP_COMMAND, 8'h00, 1'b0, 6'h00);
        send_request(OP_COMMAND, 8'hFF, 1'b1, 6'h3F);   // row/col must be ignored
        send_request(OP_COMMAND, 8'h5A, 1'b0, 6'h15);
        send_request(OP_DATA,    8'h00, 1'b1, 6'h2A);
        send_request(OP_DATA,    8'hFF, 1'b0, 6'h00);
        send_request(OP_DATA,    8'hA5, 1'b1, 6'h3F);
        send_request(OP_CURSOR,  8'hFF, 1'b0, 6'h00);   // value must be ignored
        send_request(OP_CURSOR,  8'h00, 1'b0, 6'h3F);
        send_request(OP_CURSOR,  8'h00, 1'b1, 6'h00);
        send_request(OP_CURSOR,  8'h3C, 1'b1, 6'h3F);
        send_request(OP_CURSOR,  8'h00, 1'b1, 6'h2A);
        send_request(OP_CLEAR,   8'hC3, 1'b1, 6'h3F);   // fields are don't-care
        send_request(OP_INIT,    8'h7E, 1'b1, 6'h15);
        send_request(OP_INIT,    8'h00, 1'b0, 6'h00);   // back-to-back init sequences
        send_request(OP_FIRST_UNUSED,     8'hFF, 1'b1, 6'h3F);
        send_request(OP_W'(OP_FIRST_UNUSED + 1), 8'h00, 1'b0, 6'h00);
        send_request(OP_LAST_CODE,        8'h81, 1'b1, 6'h21);
        send_request(OP_DATA,    8'h3C, 1'b0, 6'h00);   // dropped ops leave no trace

        // Random phases: all-zero waits, all-ones waits with a packed pipe, then mixes.
        run_phase(16'h0000, 16'h0000, 16'h0000, 28, 1'b1, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 28, 1'b0, 1'b1, 1'b0);
        run_phase(WAIT_W'($urandom()), WAIT_W'($urandom()), WAIT_W'($urandom()),
                  28, 1'b1, 1'b0, 1'b1);
        run_phase(16'hFFFF, 16'h0000, WAIT_W'($urandom()), 28, 1'b1, 1'b1, 1'b0);

        // Drain, then watch a little longer for words nobody asked for.
        req_ch.valid <= 1'b0;
        n = 0;
        while (n < DRAIN_LIMIT && sb.outstanding() != 0) begin
            @(posedge i_clk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d predicted words never arrived",
                                         sb.outstanding()));

        $display("tb: %0d requests: %0d command, %0d data, %0d cursor, %0d clear, %0d init",
                 sb.requests, sb.op_seen[OP_COMMAND], sb.op_seen[OP_DATA],
                 sb.op_seen[OP_CURSOR], sb.op_seen[OP_CLEAR], sb.op_seen[OP_INIT]);
        $display("tb: %0d pin words checked over five wait settings, %0d mismatches",
                 sb.events_checked, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
